### rtl/pf_pkg.sv
`default_nettype none
package pf_pkg;

  // Results per input are capped; the last one kept carries tlast.
  localparam int MaxResults = 31;
  localparam int CntW       = 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_EVAL,
    S_PUSH,
    S_FLUSH
  } pf_state_t;

endpackage
`default_nettype wire

### rtl/pf_div.sv
`default_nettype none
module pf_div #(
  parameter int W = 31
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] divisor,
  output logic              done,
  output logic [W-1:0]      quot,
  output logic [W-1:0]      rmd
);
  import pf_pkg::*;

  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  a_r;
  logic [W-1:0]  q_r;
  logic [W-1:0]  d_r;

  logic [W:0] shifted;
  logic [W:0] diff;
  logic       ge;

  // Restoring division: one quotient bit per cycle, dividend bits shift
  // out of the top of q_r while quotient bits shift in at the bottom.
  always_comb begin
    shifted = {a_r, q_r[W-1]};
    diff    = shifted - {1'b0, d_r};
    ge      = (shifted >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= '0;
      q_r <= dividend;
      d_r <= divisor;
    end else if (busy_r) begin
      a_r <= ge ? diff[W-1:0] : shifted[W-1:0];
      q_r <= {q_r[W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rmd  = a_r;

endmodule
`default_nettype wire

### rtl/prime_factorizer.sv
`default_nettype none
// Channel  Direction  Beat contents
// in_      slave      tdata: value (bits VALUE_WIDTH-1:0), zero padded to bytes
// out_     master     tdata: factor; tlast: final factor; tuser: error
//
// Trials run on a shared bit-serial divider; a found factor also passes
// through the push state. An input n takes about sqrt(n) / 3 trials plus one
// per factor. Reset (rst_n low at a clock edge) clears the output valid flag
// and the sequencer. A stalled output stops the sequencer once an output beat
// and a held-back factor both wait, unless the factor cap is reached; the last
// beat may wait there.
module prime_factorizer #(
  parameter int VALUE_WIDTH = 31
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Fields from bit 0: value.
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0] in_tdata,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // Fields from bit 0: factor.
  output logic [((VALUE_WIDTH+7)/8)*8-1:0] out_tdata,
  output logic                     out_tlast,
  // Fields from bit 0: error.
  output logic                     out_tuser,
  output logic                     out_tvalid,
  input  wire logic                out_tready
);
  import pf_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int DW = ((VALUE_WIDTH + 7) / 8) * 8;

  pf_state_t state_r, state_nxt;

  // Working cofactor and current trial divisor.
  logic [W-1:0] rem_r, rem_nxt;
  logic [W-1:0] d_r, d_nxt;
  // sub_r marks the 6k+1 member of a divisor pair; chk_r says the loop
  // bound must be checked on the coming division; tail_r says the final
  // cofactor is being pushed.
  logic sub_r, sub_nxt;
  logic chk_r, chk_nxt;
  logic tail_r, tail_nxt;

  // One factor is held back so that the last one can be flagged.
  logic [W-1:0]    pend_r, pend_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic            pend_err_r, pend_err_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] out_factor_r, out_factor_nxt;
  logic         out_last_r, out_last_nxt;
  logic         out_err_r, out_err_nxt;

  logic         div_start;
  logic         div_done;
  logic [W-1:0] div_q;
  logic [W-1:0] div_r;

  logic [W-1:0] in_value;
  logic         in_acc;
  logic         in_small;
  logic         stop;
  logic         found;
  logic         full;
  logic         rem_big;
  logic [W-1:0] new_factor;

  pf_div #(.W(W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rem_r),
    .divisor  (d_r),
    .done     (div_done),
    .quot     (div_q),
    .rmd      (div_r)
  );

  always_comb begin
    in_value   = in_tdata[W-1:0];
    in_acc     = in_tvalid && in_tready;
    in_small   = (in_value <= W'(1));
    // The loop runs while d <= remaining / d, taken from the same division.
    stop       = chk_r && (d_r > div_q);
    found      = (div_r == '0);
    full       = (cnt_r == CntW'(MaxResults));
    rem_big    = (rem_r > W'(1));
    new_factor = tail_r ? rem_r : d_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_small ? S_FLUSH : S_START;
        end
      end
      S_START: state_nxt = S_WAIT;
      S_WAIT: begin
        if (div_done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        priority if (stop) begin
          state_nxt = rem_big ? S_PUSH : S_FLUSH;
        end else if (found) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_START;
        end
      end
      S_PUSH: begin
        if (full || !pend_v_r || !out_valid_r) begin
          state_nxt = tail_r ? S_FLUSH : S_START;
        end
      end
      S_FLUSH: begin
        if (!out_valid_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = (state_r == S_IDLE);
    div_start = (state_r == S_START);
  end

  // Datapath.
  always_comb begin
    rem_nxt        = rem_r;
    d_nxt          = d_r;
    sub_nxt        = sub_r;
    chk_nxt        = chk_r;
    tail_nxt       = tail_r;
    pend_nxt       = pend_r;
    pend_v_nxt     = pend_v_r;
    pend_err_nxt   = pend_err_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_factor_nxt = out_factor_r;
    out_last_nxt   = out_last_r;
    out_err_nxt    = out_err_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // Zero and one each give a single result straight away.
          pend_nxt     = in_value;
          pend_err_nxt = (in_value == '0);
          pend_v_nxt   = in_small;
          rem_nxt      = in_value;
          d_nxt        = W'(2);
          sub_nxt      = 1'b0;
          chk_nxt      = 1'b0;
          tail_nxt     = 1'b0;
          cnt_nxt      = '0;
        end
      end
      S_EVAL: begin
        priority if (stop) begin
          tail_nxt = rem_big;
        end else if (found) begin
          // Keep dividing by the same divisor without the bound check.
          rem_nxt = div_q;
          chk_nxt = 1'b0;
        end else if (d_r == W'(2)) begin
          d_nxt = W'(3);
        end else if (d_r == W'(3)) begin
          d_nxt   = W'(5);
          sub_nxt = 1'b0;
          chk_nxt = 1'b1;
        end else if (!sub_r) begin
          d_nxt   = d_r + W'(2);
          sub_nxt = 1'b1;
          chk_nxt = 1'b0;
        end else begin
          d_nxt   = d_r + W'(4);
          sub_nxt = 1'b0;
          chk_nxt = 1'b1;
        end
      end
      S_PUSH: begin
        priority if (full) begin
          // Beyond the cap further factors are dropped.
        end else if (!pend_v_r) begin
          pend_nxt   = new_factor;
          pend_v_nxt = 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
        end else if (!out_valid_r) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = pend_r;
          out_last_nxt   = 1'b0;
          out_err_nxt    = pend_err_r;
          pend_nxt       = new_factor;
          cnt_nxt        = cnt_r + 1'b1;
        end
      end
      S_FLUSH: begin
        if (!out_valid_r) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = pend_r;
          out_last_nxt   = 1'b1;
          out_err_nxt    = pend_err_r;
          pend_v_nxt     = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      tail_r      <= 1'b0;
      chk_r       <= 1'b0;
      sub_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
      cnt_r       <= cnt_nxt;
      tail_r      <= tail_nxt;
      chk_r       <= chk_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r        <= rem_nxt;
    d_r          <= d_nxt;
    pend_r       <= pend_nxt;
    pend_err_r   <= pend_err_nxt;
    out_factor_r <= out_factor_nxt;
    out_last_r   <= out_last_nxt;
    out_err_r    <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DW'(out_factor_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  // The divider only finishes while the sequencer waits for it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_WAIT))
    else $error("divider finished outside the wait state");

  // The factor count never passes the cap.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxResults))
    else $error("factor count above cap");

  // A zero input goes straight to a flagged final result.
  a_zero_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_value == '0) |=> (state_r == S_FLUSH && pend_err_r && pend_v_r))
    else $error("zero input not routed to error result");

endmodule
`default_nettype wire
